// File: design/assert_macros.svh
// assertion macros used by the top level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is applied
`define ORS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked assertion that is checked during reset as well
`define ORS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/ors_pkg.sv
// types, codes and constants of the 1-wire rom search engine
package ors_pkg;

	localparam int MAX_DEVICES = 16;

	localparam logic [6:0] ROM_BITS     = 7'd64;
	localparam logic [6:0] LAST_BIT_POS = 7'd63;
	localparam logic [6:0] FIRST_PASS   = 7'd65;
	localparam logic [4:0] TALLY_MAX    = 5'd31;

	typedef enum logic [1:0] {
		FN_START = 2'd0,
		FN_PASS  = 2'd1,
		FN_BIT   = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED    = 3'd0,
		ST_BIT_OK      = 3'd1,
		ST_FOUND_MORE  = 3'd2,
		ST_FOUND_LAST  = 3'd3,
		ST_NO_PRESENCE = 3'd4,
		ST_DATA_ERROR  = 3'd5,
		ST_ORDER       = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_READY  = 2'd1,
		PH_SEARCH = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	typedef struct packed {
		func_t func;
		logic  presence;
		logic  id_bit;
		logic  cmp_bit;
	} req_t;

	typedef struct packed {
		logic        write_bit;
		status_t     status;
		logic [63:0] rom_id;
		logic [4:0]  found_count;
	} rsp_t;

	typedef struct packed {
		logic [63:0] rom_shift;
		logic [6:0]  last_disc;
		logic [6:0]  next_disc;
		logic [6:0]  bit_pos;
		logic [4:0]  tally;
		phase_t      phase;
	} search_state_t;

endpackage

// File: design/ors_decide.sv
// search decision logic: next search state and response for one request
module ors_decide
	import ors_pkg::*;
(
	input  req_t          req,
	input  search_state_t cur,
	output search_state_t nxt,
	output rsp_t          rsp
);

	logic [6:0]  pos;
	logic        prev;
	logic        take_one;
	logic        dir_bit;
	logic [6:0]  disc_new;
	logic [63:0] shift_new;
	logic [4:0]  tally_new;
	logic        limit_hit;

	// positions count down from 64 for the first bit to 1 for the last
	assign pos       = ROM_BITS - cur.bit_pos;
	assign prev      = cur.rom_shift[0];
	assign take_one  = (cur.last_disc > pos) || (prev && (cur.last_disc != pos));
	assign dir_bit   = (!req.id_bit && !req.cmp_bit) ? take_one : req.id_bit;
	assign disc_new  = (!req.id_bit && !req.cmp_bit && take_one) ? pos : cur.next_disc;
	assign shift_new = {dir_bit, cur.rom_shift[63:1]};
	assign tally_new = (cur.tally < TALLY_MAX) ? cur.tally + 5'd1 : cur.tally;
	assign limit_hit = {3'b000, tally_new} >= 8'(MAX_DEVICES);

	always_comb begin
		nxt        = cur;
		rsp        = '0;
		rsp.status = ST_ORDER;
		case (req.func)
			FN_START: begin
				nxt.rom_shift = '0;
				nxt.last_disc = FIRST_PASS;
				nxt.next_disc = '0;
				nxt.bit_pos   = '0;
				nxt.tally     = '0;
				nxt.phase     = PH_READY;
				rsp.status    = ST_ACCEPTED;
			end
			FN_PASS: begin
				if (cur.phase == PH_READY) begin
					if (!req.presence) begin
						nxt.phase  = PH_DONE;
						rsp.status = ST_NO_PRESENCE;
					end else begin
						nxt.bit_pos   = '0;
						nxt.next_disc = '0;
						nxt.phase     = PH_SEARCH;
						rsp.status    = ST_ACCEPTED;
					end
				end
			end
			FN_BIT: begin
				if (cur.phase == PH_SEARCH && cur.bit_pos < ROM_BITS) begin
					if (req.id_bit && req.cmp_bit) begin
						nxt.phase  = PH_DONE;
						rsp.status = ST_DATA_ERROR;
					end else begin
						nxt.rom_shift = shift_new;
						nxt.next_disc = disc_new;
						nxt.bit_pos   = cur.bit_pos + 7'd1;
						rsp.write_bit = dir_bit;
						if (cur.bit_pos != LAST_BIT_POS) begin
							rsp.status = ST_BIT_OK;
						end else begin
							// rom complete: close the pass
							nxt.last_disc = disc_new;
							nxt.tally     = tally_new;
							nxt.phase     = (disc_new == '0 || limit_hit) ? PH_DONE : PH_READY;
							rsp.status    = (disc_new == '0) ? ST_FOUND_LAST : ST_FOUND_MORE;
							rsp.rom_id    = shift_new;
						end
					end
				end
			end
			default: begin
				rsp.status = ST_ORDER;
			end
		endcase
		rsp.found_count = nxt.tally;
	end

endmodule

// File: design/onewire_rom_search_engine.sv
// top level of the 1-wire rom search engine: request register, search state, response register
//
//  channel  signals                     direction  carries
//  req      req_valid req_stall req_data  into     func, presence, id_bit, cmp_bit
//  rsp      rsp_valid rsp_stall rsp_data  out of   write_bit, status, rom_id, found_count
//
// one request per cycle sustained while the response is not stalled
// the request register feeds the decision logic, which updates the search state and
// loads the response register in the same cycle
// reset returns the search state to idle with the first pass marker and empties both stages
// a stalled response holds; the request register keeps taking requests while it can drain
`include "assert_macros.svh"

module onewire_rom_search_engine
	import ors_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_data,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp_data
);

	logic          valid_s1;
	req_t          req_s1;
	logic          valid_s2;
	rsp_t          rsp_s2;
	search_state_t state_q;
	search_state_t state_nxt;
	rsp_t          rsp_nxt;
	logic          adv_s1;

	ors_decide u_decide (
		.req (req_s1),
		.cur (state_q),
		.nxt (state_nxt),
		.rsp (rsp_nxt)
	);

	assign adv_s1    = valid_s1 && (!valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && !adv_s1;
	assign rsp_valid = valid_s2;
	assign rsp_data  = rsp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1          <= 1'b0;
			valid_s2          <= 1'b0;
			state_q.rom_shift <= '0;
			state_q.last_disc <= FIRST_PASS;
			state_q.next_disc <= '0;
			state_q.bit_pos   <= '0;
			state_q.tally     <= '0;
			state_q.phase     <= PH_IDLE;
		end else begin
			if (!valid_s1 || adv_s1) begin
				valid_s1 <= req_valid;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (!rsp_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (!valid_s1 || adv_s1) begin
			req_s1 <= req_data;
		end
		if (adv_s1) begin
			rsp_s2 <= rsp_nxt;
		end
	end

	`ORS_ASSERT(a_search_pos_range, state_q.phase == PH_SEARCH |-> state_q.bit_pos < ROM_BITS, "bit position beyond rom while searching")
	`ORS_ASSERT(a_found_ends_pass, (adv_s1 && (rsp_nxt.status == ST_FOUND_MORE || rsp_nxt.status == ST_FOUND_LAST)) |=> state_q.phase != PH_SEARCH && state_q.bit_pos == ROM_BITS, "found rom did not close the pass")
	`ORS_ASSERT(a_rom_only_on_found, (rsp_valid && rsp_data.status != ST_FOUND_MORE && rsp_data.status != ST_FOUND_LAST) |-> rsp_data.rom_id == '0, "rom id set on a non-found response")
	`ORS_ASSERT_ALWAYS(a_stall_needs_item, req_stall |-> valid_s1 && valid_s2 && rsp_stall, "request stalled without a blocked item")

endmodule

// File: verif/rom_search_check_pkg.sv
// rom search decision predictor and response checker used by the testbench
package rom_search_check_pkg;
	import ors_pkg::*;

	class search_checker;
		logic [63:0] rom_shift;
		logic [6:0]  last_disc;
		logic [6:0]  next_disc;
		logic [6:0]  bit_pos;
		logic [4:0]  tally;
		phase_t      phase;
		logic        last_direction;
		rsp_t        pending_answers[$];
		int          mismatches;
		int          responses_seen;

		function new();
			clear_enumeration();
			phase = PH_IDLE;
			last_direction = 1'b0;
			mismatches = 0;
			responses_seen = 0;
		endfunction

		function void clear_enumeration();
			rom_shift = '0;
			last_disc = FIRST_PASS;
			next_disc = '0;
			bit_pos = '0;
			tally = '0;
		endfunction

		function int pending();
			return pending_answers.size();
		endfunction

		// work out the answer to one accepted request and queue it
		function void note_request(req_t r);
			rsp_t       e;
			logic [6:0] pos;
			logic       dir;
			e = '0;
			e.status = ST_ORDER;
			case (r.func)
				FN_START: begin
					clear_enumeration();
					phase = PH_READY;
					e.status = ST_ACCEPTED;
				end
				FN_PASS: begin
					if (phase == PH_READY) begin
						if (!r.presence) begin
							phase = PH_DONE;
							e.status = ST_NO_PRESENCE;
						end else begin
							bit_pos = '0;
							next_disc = '0;
							phase = PH_SEARCH;
							e.status = ST_ACCEPTED;
						end
					end
				end
				FN_BIT: begin
					if (phase == PH_SEARCH && bit_pos < ROM_BITS) begin
						// positions count down from 64 at the first bit
						pos = ROM_BITS - bit_pos;
						if (r.id_bit && r.cmp_bit) begin
							phase = PH_DONE;
							e.status = ST_DATA_ERROR;
						end else begin
							dir = r.id_bit;
							if (!r.id_bit && !r.cmp_bit) begin
								// take the 1 branch first at a discrepancy
								if (last_disc > pos || (rom_shift[0] && last_disc != pos)) begin
									dir = 1'b1;
									next_disc = pos;
								end else begin
									dir = 1'b0;
								end
							end
							rom_shift = {dir, rom_shift[63:1]};
							bit_pos++;
							last_direction = dir;
							e.write_bit = dir;
							e.status = ST_BIT_OK;
							if (bit_pos == ROM_BITS) begin
								last_disc = next_disc;
								if (tally < TALLY_MAX)
									tally++;
								phase = (next_disc == 0 || tally >= MAX_DEVICES) ? PH_DONE : PH_READY;
								e.status = (next_disc == 0) ? ST_FOUND_LAST : ST_FOUND_MORE;
								e.rom_id = rom_shift;
							end
						end
					end
				end
				default: ;
			endcase
			e.found_count = tally;
			pending_answers.push_back(e);
		endfunction

		function void check_response(rsp_t got);
			rsp_t e;
			responses_seen++;
			if (pending_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response: write_bit %0b status %0d rom_id %h count %0d",
						got.write_bit, got.status, got.rom_id, got.found_count);
				return;
			end
			e = pending_answers.pop_front();
			if (got.write_bit !== e.write_bit || got.status !== e.status ||
				got.rom_id !== e.rom_id || got.found_count !== e.found_count) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: expected write_bit %0b status %0d rom_id %h count %0d",
						e.write_bit, e.status, e.rom_id, e.found_count);
					$display("          actual   write_bit %0b status %0d rom_id %h count %0d",
						got.write_bit, got.status, got.rom_id, got.found_count);
				end
			end
		endfunction
	endclass

endpackage

// File: verif/tb.sv
// testbench of the 1-wire rom search engine with a simulated population of bus devices
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ors_pkg::*;
	import rom_search_check_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_data = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_data;

	search_checker sb = new();
	int items_sent = 0;
	int burst_left = 0;

	onewire_rom_search_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data (rsp_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic req_t make_req(func_t f, logic p, logic i, logic c);
		req_t r;
		r.func = f;
		r.presence = p;
		r.id_bit = i;
		r.cmp_bit = c;
		return r;
	endfunction

	// mostly back to back, sometimes short gaps, a few long ones
	function int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0)
			burst_left = $urandom_range(20, 80);
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(11, 30);
	endfunction

	task automatic send_req(input req_t r);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req_data <= r;
		do @(posedge clk); while (req_stall);
		sb.note_request(r);
		items_sent++;
	endtask

	task automatic drain_responses();
		do begin
			@(negedge clk);
			req_valid <= 1'b0;
		end while (sb.pending() != 0);
	endtask

	task automatic send_junk();
		send_req(make_req(func_t'($urandom_range(0, 2)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
	endtask

	// one enumeration against ndev devices; the devices follow the predicted direction
	task automatic run_enumeration(input int ndev);
		logic [63:0] bus_rom[20];
		logic [63:0] base;
		bit   [19:0] active;
		int          passes;
		int          i;
		int          style;
		logic        all_one;
		logic        all_zero;
		logic        dir;
		logic        pres;
		base = {$urandom(), $urandom()};
		style = $urandom_range(0, 3);
		for (int k = 0; k < 20; k++) begin
			if (style == 0)
				bus_rom[k] = {$urandom(), $urandom()};
			else
				bus_rom[k] = base ^ (64'd1 << $urandom_range(0, 63)) ^
					(64'd1 << $urandom_range(0, 63));
		end
		// single device with an all-zero or all-one rom
		if (ndev == 1 && $urandom_range(0, 3) == 0)
			bus_rom[0] = $urandom_range(0, 1) ? '1 : '0;
		send_req(make_req(FN_START, 1'b0, 1'b0, 1'b0));
		passes = 0;
		while (sb.phase == PH_READY && passes < 40) begin
			passes++;
			pres = (ndev > 0);
			if ($urandom_range(0, 24) == 0)
				pres = 1'($urandom_range(0, 1));
			send_req(make_req(FN_PASS, pres, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1))));
			active = '1;
			i = 0;
			while (i < 64 && sb.phase == PH_SEARCH) begin
				if ($urandom_range(0, 299) == 0) begin
					// stray pass request or restart in the middle of a search
					send_req(make_req($urandom_range(0, 1) ? FN_PASS : FN_START,
						1'($urandom_range(0, 1)), 1'b0, 1'b0));
				end else begin
					all_one = 1'b1;
					all_zero = 1'b1;
					for (int k = 0; k < ndev; k++) begin
						if (active[k]) begin
							if (bus_rom[k][i])
								all_zero = 1'b0;
							else
								all_one = 1'b0;
						end
					end
					// wired-and bus: nobody left reads as 11
					if ($urandom_range(0, 299) == 0)
						send_req(make_req(FN_BIT, 1'($urandom_range(0, 1)),
							1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
					else
						send_req(make_req(FN_BIT, 1'($urandom_range(0, 1)),
							all_one, all_zero));
					dir = sb.last_direction;
					for (int k = 0; k < ndev; k++)
						if (bus_rom[k][i] !== dir)
							active[k] = 1'b0;
					i++;
				end
			end
		end
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) send_junk();
	endtask

	// receiver: random stalls plus one long hold-off once traffic is flowing
	initial begin
		int  stall_len;
		int  free_len;
		bit  held;
		held = 0;
		@(posedge arst_n);
		forever begin
			if (!held && sb.responses_seen >= 400) begin
				held = 1;
				repeat (300) begin
					@(negedge clk);
					rsp_stall <= 1'b1;
				end
			end
			stall_len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(10, 40);
			free_len = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
			repeat (stall_len) begin
				@(negedge clk);
				rsp_stall <= 1'b1;
			end
			repeat (free_len) begin
				@(negedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(rsp_data);
	end

	initial begin
		bit paused;
		bit big_done;
		int ndev;
		paused = 0;
		big_done = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// out of order before any start, no presence, data error, first pass
		// discrepancy, pass during a search and restart in the middle of one
		send_req(make_req(FN_BIT, 1'b0, 1'b0, 1'b0));
		send_req(make_req(FN_PASS, 1'b1, 1'b0, 1'b0));
		send_req(make_req(FN_START, 1'b1, 1'b1, 1'b1));
		send_req(make_req(FN_PASS, 1'b0, 1'b0, 1'b0));
		send_req(make_req(FN_PASS, 1'b1, 1'b0, 1'b0));
		send_req(make_req(FN_BIT, 1'b0, 1'b0, 1'b0));
		send_req(make_req(FN_START, 1'b0, 1'b0, 1'b0));
		send_req(make_req(FN_PASS, 1'b1, 1'b0, 1'b0));
		send_req(make_req(FN_BIT, 1'b0, 1'b1, 1'b1));
		send_req(make_req(FN_BIT, 1'b0, 1'b0, 1'b1));
		send_req(make_req(FN_START, 1'b0, 1'b0, 1'b0));
		send_req(make_req(FN_PASS, 1'b1, 1'b1, 1'b1));
		send_req(make_req(FN_BIT, 1'b1, 1'b0, 1'b0));
		send_req(make_req(FN_BIT, 1'b0, 1'b0, 1'b1));
		send_req(make_req(FN_BIT, 1'b0, 1'b1, 1'b0));
		send_req(make_req(FN_BIT, 1'b0, 1'b0, 1'b0));
		send_req(make_req(FN_PASS, 1'b1, 1'b0, 1'b0));
		send_req(make_req(FN_START, 1'b0, 1'b0, 1'b0));
		send_req(make_req(FN_BIT, 1'b0, 1'b1, 1'b0));

		while (items_sent < 1900) begin
			if (!paused && items_sent > 1000) begin
				paused = 1;
				drain_responses();
			end
			if (!big_done && items_sent > 300) begin
				// more devices than the limit allows
				big_done = 1;
				ndev = $urandom_range(17, 20);
			end else begin
				ndev = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 5);
			end
			run_enumeration(ndev);
		end

		drain_responses();
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
